FILE: sv/rpr_pkg.sv
// Shared constants, codes and controller/datapath handshake types for palette reduction.
package rpr_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int PALETTE_ENTRIES = 256;
    localparam int AW              = $clog2(TABLE_DEPTH);
    localparam int CW              = AW + 1;

    localparam logic [1:0] OP_COLLECT = 2'd0;
    localparam logic [1:0] OP_FINISH  = 2'd1;
    localparam logic [1:0] OP_MAP     = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_MISS     = 2'd2;

    typedef struct packed {
        logic load_in;
        logic k_inc;
        logic i_inc;
        logic i_clr;
        logic fp_inc;
        logic rd_list_k;
        logic rd_list_i;
        logic rd_pal_k;
        logic rd_pal_slot;
        logic lst_wr;
        logic set_ovf;
        logic clr_list;
        logic clr_taken;
        logic take_k;
        logic pal_wr_fp;
        logic st_ovf;
        logic st_miss;
        logic set_index;
        logic load_rgb;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       list_hit;
        logic       k_at_count;
        logic       k_last;
        logic       count_full;
        logic       ovf;
        logic       pal_hit_free;
        logic       pal_hit;
        logic       i_at_count;
        logic       placed_i;
        logic       taken_fp;
        logic       slot_ok;
        logic       out_busy;
    } t_stat;

endpackage

FILE: sv/rpr_if.sv
// Valid/ready channel interfaces for pixel requests and results.
interface rpr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] slot;
    modport source (output valid, operation, red, green, blue, slot, input ready);
    modport sink   (input valid, operation, red, green, blue, slot, output ready);
endinterface

interface rpr_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] palette_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [8:0] colour_count;
    modport source (output valid, status, palette_index, out_red, out_green, out_blue,
                    colour_count, input ready);
    modport sink   (input valid, status, palette_index, out_red, out_green, out_blue,
                    colour_count, output ready);
endinterface

FILE: sv/rgb_palette_reduction_core.sv
// Palette reduction top level: one transaction in, one result out, handled one at a time.
// A transaction is processed alone from acceptance to result. Collect scans the collection
// list one entry at a time through its single read port and stops early on a match. Map
// scans palette slots in order until a match or the last slot. Finish walks the palette
// once per collected colour and then fills free slots with a rising pointer. A result
// waits in an output register, so the next transaction is accepted while it is held.
module rgb_palette_reduction_core
    import rpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpr_in_if.sink    i_pix,
    rpr_out_if.source o_res
);

    t_cmd  cmd;
    t_stat stat;

    rpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rpr_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

endmodule

FILE: sv/rpr_datapath.sv
// Datapath: collection list, palette memory, working flags, scan counters and result registers.
module rpr_datapath
    import rpr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_stat         o_stat,
    rpr_in_if.sink        i_pix,
    rpr_out_if.source     o_res
);

    logic [TABLE_DEPTH-1:0] r_list_mem [0:0];
    logic [23:0] r_list [TABLE_DEPTH];
    logic [23:0] r_pal  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_pal_v;
    logic [TABLE_DEPTH-1:0] r_taken;
    logic [TABLE_DEPTH-1:0] r_placed;

    logic [1:0]    r_op;
    logic [23:0]   r_colour;
    logic [AW-1:0] r_slot;
    logic [CW-1:0] r_k, r_i, r_fp, r_count;
    logic          r_ovf;
    logic [23:0]   r_list_q;
    logic [23:0]   r_pal_raw;
    logic          r_pal_vq;
    logic [23:0]   pal_q;
    logic [1:0]    r_status;
    logic [AW-1:0] r_index;
    logic [23:0]   r_rgb;
    logic          r_out_valid;
    logic [1:0]    r_o_status;
    logic [AW-1:0] r_o_index;
    logic [23:0]   r_o_rgb;
    logic [CW-1:0] r_o_count;
    logic [AW-1:0] pal_addr;

    assign r_list_mem[0] = r_pal_v;
    assign pal_q    = r_pal_vq ? r_pal_raw : 24'd0;
    assign pal_addr = i_cmd.rd_pal_slot ? r_slot : r_k[AW-1:0];

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.lst_wr) begin
            r_list[r_count[AW-1:0]] <= r_colour;
        end
        if (i_cmd.rd_list_k) begin
            r_list_q <= r_list[r_k[AW-1:0]];
        end else if (i_cmd.rd_list_i) begin
            r_list_q <= r_list[r_i[AW-1:0]];
        end
        if (i_cmd.pal_wr_fp) begin
            r_pal[r_fp[AW-1:0]] <= r_list_q;
        end
        if (i_cmd.rd_pal_k || i_cmd.rd_pal_slot) begin
            r_pal_raw <= r_pal[pal_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_v     <= '0;
            r_taken     <= '0;
            r_placed    <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pal_vq    <= 1'b0;
        end else begin
            if (i_cmd.rd_pal_k || i_cmd.rd_pal_slot) begin
                r_pal_vq <= r_list_mem[0][pal_addr];
            end
            if (i_cmd.pal_wr_fp) begin
                r_pal_v[r_fp[AW-1:0]] <= 1'b1;
                r_taken[r_fp[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.clr_taken) begin
                r_taken  <= '0;
                r_placed <= '0;
            end
            if (i_cmd.take_k) begin
                r_taken[r_k[AW-1:0]]  <= 1'b1;
                r_placed[r_i[AW-1:0]] <= 1'b1;
            end
            if (i_cmd.lst_wr) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.clr_list) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op     <= i_pix.operation;
            r_colour <= {i_pix.red, i_pix.green, i_pix.blue};
            r_slot   <= i_pix.slot;
            r_k      <= '0;
            r_i      <= '0;
            r_fp     <= '0;
            r_status <= ST_OK;
            r_index  <= '0;
            r_rgb    <= '0;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.i_inc) begin
                r_i <= r_i + 1'b1;
                r_k <= '0;
            end
            // Restart the list walk for the second pass.
            if (i_cmd.i_clr) begin
                r_i <= '0;
            end
            if (i_cmd.fp_inc) begin
                r_fp <= r_fp + 1'b1;
            end
            if (i_cmd.st_ovf) begin
                r_status <= ST_OVERFLOW;
            end
            if (i_cmd.st_miss) begin
                r_status <= ST_MISS;
            end
            if (i_cmd.set_index) begin
                r_index <= r_k[AW-1:0];
            end
            if (i_cmd.load_rgb) begin
                r_rgb <= pal_q;
            end
        end
        if (i_cmd.emit) begin
            r_o_status <= r_status;
            r_o_index  <= r_index;
            r_o_rgb    <= r_rgb;
            r_o_count  <= r_count;
        end
    end

    always_comb begin
        o_stat.op           = r_op;
        o_stat.list_hit     = (r_list_q == r_colour);
        o_stat.k_at_count   = (r_k == r_count);
        o_stat.k_last       = (r_k == CW'(PALETTE_ENTRIES - 1));
        o_stat.count_full   = (r_count >= CW'(PALETTE_ENTRIES));
        o_stat.ovf          = r_ovf;
        o_stat.pal_hit_free = !r_taken[r_k[AW-1:0]] && (pal_q == r_list_q);
        o_stat.pal_hit      = (pal_q == r_colour);
        o_stat.i_at_count   = (r_i == r_count);
        o_stat.placed_i     = r_placed[r_i[AW-1:0]];
        o_stat.taken_fp     = r_taken[r_fp[AW-1:0]];
        o_stat.slot_ok      = ({1'b0, r_slot} < CW'(PALETTE_ENTRIES));
        o_stat.out_busy     = r_out_valid && !o_res.ready;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_o_status;
    assign o_res.palette_index = r_o_index;
    assign o_res.out_red       = r_o_rgb[23:16];
    assign o_res.out_green     = r_o_rgb[15:8];
    assign o_res.out_blue      = r_o_rgb[7:0];
    assign o_res.colour_count  = r_o_count;

endmodule

FILE: sv/rpr_ctrl.sv
// Controller: sequences collect, finish, map and read operations over the datapath.
module rpr_ctrl
    import rpr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_C_RD   = 4'd1;
    localparam logic [3:0] S_C_CMP  = 4'd2;
    localparam logic [3:0] S_C_FIN  = 4'd3;
    localparam logic [3:0] S_M_RD   = 4'd4;
    localparam logic [3:0] S_M_CMP  = 4'd5;
    localparam logic [3:0] S_R_RD   = 4'd6;
    localparam logic [3:0] S_R_CMP  = 4'd7;
    localparam logic [3:0] S_F_START= 4'd8;
    localparam logic [3:0] S_P1_I   = 4'd9;
    localparam logic [3:0] S_P1_RD  = 4'd10;
    localparam logic [3:0] S_P1_CMP = 4'd11;
    localparam logic [3:0] S_P2_I   = 4'd12;
    localparam logic [3:0] S_P2_FP  = 4'd13;
    localparam logic [3:0] S_EMIT   = 4'd14;

    logic [3:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_R_RD;
                end
            end
            S_R_RD: begin
                // Dispatch on the captured operation.
                case (i_stat.op)
                    OP_COLLECT: n_state = S_C_RD;
                    OP_FINISH:  n_state = S_F_START;
                    OP_MAP:     n_state = S_M_RD;
                    default: begin
                        if (i_stat.slot_ok) begin
                            o_cmd.rd_pal_slot = 1'b1;
                            n_state = S_R_CMP;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                endcase
            end
            S_R_CMP: begin
                o_cmd.load_rgb = 1'b1;
                n_state = S_EMIT;
            end
            S_C_RD: begin
                if (i_stat.k_at_count) begin
                    if (i_stat.count_full) begin
                        o_cmd.set_ovf = 1'b1;
                    end else begin
                        o_cmd.lst_wr = 1'b1;
                    end
                    n_state = S_C_FIN;
                end else begin
                    o_cmd.rd_list_k = 1'b1;
                    n_state = S_C_CMP;
                end
            end
            S_C_CMP: begin
                if (i_stat.list_hit) begin
                    n_state = S_C_FIN;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_C_RD;
                end
            end
            S_C_FIN: begin
                o_cmd.st_ovf = i_stat.ovf;
                n_state = S_EMIT;
            end
            S_M_RD: begin
                o_cmd.rd_pal_k = 1'b1;
                n_state = S_M_CMP;
            end
            S_M_CMP: begin
                if (i_stat.pal_hit) begin
                    o_cmd.set_index = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.k_last) begin
                    o_cmd.st_miss = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_M_RD;
                end
            end
            S_F_START: begin
                if (i_stat.ovf) begin
                    o_cmd.st_ovf   = 1'b1;
                    o_cmd.clr_list = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.clr_taken = 1'b1;
                    n_state = S_P1_I;
                end
            end
            // First pass: keep colours already in the palette.
            S_P1_I: begin
                if (i_stat.i_at_count) begin
                    o_cmd.i_clr = 1'b1;
                    n_state = S_P2_I;
                end else begin
                    o_cmd.rd_list_i = 1'b1;
                    n_state = S_P1_RD;
                end
            end
            S_P1_RD: begin
                o_cmd.rd_pal_k = 1'b1;
                n_state = S_P1_CMP;
            end
            S_P1_CMP: begin
                if (i_stat.pal_hit_free) begin
                    o_cmd.take_k = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    n_state = S_P1_I;
                end else if (i_stat.k_last) begin
                    o_cmd.i_inc = 1'b1;
                    n_state = S_P1_I;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_P1_RD;
                end
            end
            // Second pass: new colours into the lowest free slots.
            S_P2_I: begin
                if (i_stat.i_at_count) begin
                    o_cmd.clr_list = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.placed_i) begin
                    o_cmd.i_inc = 1'b1;
                end else begin
                    o_cmd.rd_list_i = 1'b1;
                    n_state = S_P2_FP;
                end
            end
            S_P2_FP: begin
                if (i_stat.taken_fp) begin
                    o_cmd.fp_inc = 1'b1;
                end else begin
                    o_cmd.pal_wr_fp = 1'b1;
                    o_cmd.i_inc     = 1'b1;
                    n_state = S_P2_I;
                end
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
